/* sv/hkd_pkg.sv */
// Shared widths, constants, state codes and control structs of the histogram distance scorer.
package hkd_pkg;

  localparam int BinW    = 16;
  localparam int DistW   = 23;
  localparam int TotalW  = 35;
  localparam int CountW  = 13;
  localparam int MeanW   = 23;
  localparam int WeightW = 16;
  localparam int AccW    = DistW + WeightW + 1;

  localparam logic [DistW-1:0]  DistMax  = {DistW{1'b1}};
  localparam logic [TotalW-1:0] TotalMax = {TotalW{1'b1}};

  // Queries beyond this count are dropped from the total and the count
  localparam int MaxQueries = 4096;
  localparam logic [CountW-1:0] CountLimit =
    (MaxQueries < 8191) ? CountW'(MaxQueries) : CountW'(8191);

  typedef enum logic [2:0] {
    StIdle,
    StScore,
    StDrain,
    StTotal,
    StDivStart,
    StDivWait
  } hkd_state_t;

  // Control of one list cell: sorted insert or shift toward the head
  typedef struct packed {
    logic insert;
    logic shift;
  } hkd_cell_ctl_t;

  // Divider status
  typedef struct packed {
    logic busy;
    logic done;
  } hkd_div_stat_t;

endpackage

/* sv/hkd_if.sv */
// Valid/ready channels for bin pair beats and result beats.
interface hkd_in_if;
  logic                        valid;
  logic                        ready;
  logic [hkd_pkg::BinW-1:0]    query_bin;
  logic [hkd_pkg::BinW-1:0]    target_bin;
  logic                        last_bin;
  logic                        last_target;
  logic                        last_query;

  modport source (output valid, output query_bin, output target_bin, output last_bin,
                  output last_target, output last_query, input ready);
  modport sink   (input valid, input query_bin, input target_bin, input last_bin,
                  input last_target, input last_query, output ready);
endinterface

interface hkd_out_if;
  logic                        valid;
  logic                        ready;
  logic [hkd_pkg::TotalW-1:0]  total_score;
  logic [hkd_pkg::CountW-1:0]  query_count;
  logic [hkd_pkg::MeanW-1:0]   mean_score;

  modport source (output valid, output total_score, output query_count,
                  output mean_score, input ready);
  modport sink   (input valid, input total_score, input query_count,
                  input mean_score, output ready);
endinterface

/* sv/hkd_cell.sv */
// One slot of the sorted nearest-distance list.
module hkd_cell (
  input  logic                         clk,
  input  logic                         rst_n,
  input  hkd_pkg::hkd_cell_ctl_t       ctl,
  input  logic [hkd_pkg::DistW-1:0]    ins_dist,
  input  logic                         left_le,
  input  logic [hkd_pkg::DistW-1:0]    left_val,
  input  logic [hkd_pkg::DistW-1:0]    right_val,
  output logic                         le,
  output logic [hkd_pkg::DistW-1:0]    val
);

  logic [hkd_pkg::DistW-1:0] val_r;
  logic [hkd_pkg::DistW-1:0] val_nxt;

  // Keep our entry if it does not exceed the new distance
  assign le  = (val_r <= ins_dist);
  assign val = val_r;

  // Shift takes the right entry; insert keeps, takes new or the left entry
  always_comb begin
    val_nxt = val_r;
    if (ctl.shift) begin
      val_nxt = right_val;
    end else if (ctl.insert && !le) begin
      val_nxt = left_le ? ins_dist : left_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= hkd_pkg::DistMax;
    end else begin
      val_r <= val_nxt;
    end
  end

endmodule

/* sv/hkd_div.sv */
// Restoring divider, one quotient bit per cycle, for the mean score.
module hkd_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [hkd_pkg::TotalW-1:0]    dividend,
  input  logic [hkd_pkg::CountW-1:0]    divisor,
  output hkd_pkg::hkd_div_stat_t        stat,
  output logic [hkd_pkg::TotalW-1:0]    quotient
);

  localparam int StepW = $clog2(hkd_pkg::TotalW);

  logic                         busy_r;
  logic                         done_r;
  logic [StepW-1:0]             step_r;
  logic [hkd_pkg::TotalW-1:0]   quo_r;
  logic [hkd_pkg::CountW-1:0]   rem_r;
  logic [hkd_pkg::CountW:0]     trial;
  logic                         ge;
  logic [hkd_pkg::CountW:0]     diff;

  // Bring down the next dividend bit and try a subtract
  assign trial = {rem_r, quo_r[hkd_pkg::TotalW-1]};
  assign ge    = (trial >= {1'b0, divisor});
  assign diff  = trial - {1'b0, divisor};

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

  // Sequence the steps
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      step_r <= '0;
    end else if (busy_r) begin
      step_r <= step_r + StepW'(1);
      if (step_r == StepW'(hkd_pkg::TotalW - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // Shift quotient bits in and keep the partial remainder
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      quo_r <= {quo_r[hkd_pkg::TotalW-2:0], ge};
      rem_r <= ge ? diff[hkd_pkg::CountW-1:0] : trial[hkd_pkg::CountW-1:0];
    end
  end

endmodule

/* sv/histogram_knn_distance_score.sv */
// Top level of the K-nearest L1 histogram distance scorer.
//
// in_bus carries one bin pair per beat (query_bin, target_bin, unsigned Q7.9)
// with last_bin / last_target / last_query flags; out_bus carries one result
// beat (total_score, query_count, mean_score) per final query.
// A bin beat is taken every cycle while the block is idle. The L1 sum of a
// pair is formed on the fly; on last_bin it is inserted into a row of
// K_NEAREST cells in the same cycle. On last_target the row shifts its
// entries into one multiplier, one per cycle, and refills with the empty
// sentinel; input is held off after that beat through the drain and total steps.
// On last_query a divider start step follows, and the block waits for the
// bit-serial divider to form the mean before it loads the result beat.
// The result waits in an output register, and bin beats for the next run
// are taken while it waits. A further final query stalls in the divider
// stage until the previous result beat has been taken.
// Synchronous reset clears the list to the sentinel, the pair sum, the
// total and the count, and drops any pending result.
module histogram_knn_distance_score #(
  parameter int K_NEAREST = 5
) (
  input  logic     clk,
  input  logic     rst_n,
  hkd_in_if.sink   in_bus,
  hkd_out_if.source out_bus
);

  localparam int CntW = (K_NEAREST > 1) ? $clog2(K_NEAREST) : 1;
  localparam int DW   = hkd_pkg::DistW;
  localparam int AW   = hkd_pkg::AccW;

  hkd_pkg::hkd_state_t state_r;
  hkd_pkg::hkd_state_t state_nxt;

  logic [DW-1:0]                 pair_r;
  logic [CntW-1:0]               cnt_r;
  logic                          qlast_r;
  logic [DW+hkd_pkg::WeightW-1:0] prod_r;
  logic                          prod_v_r;
  logic [AW-1:0]                 acc_r;
  logic [hkd_pkg::TotalW-1:0]    total_r;
  logic [hkd_pkg::CountW-1:0]    count_r;

  logic                          out_valid_r;
  logic [hkd_pkg::TotalW-1:0]    out_total_r;
  logic [hkd_pkg::CountW-1:0]    out_count_r;
  logic [hkd_pkg::MeanW-1:0]     out_mean_r;

  logic                          accept;
  logic [hkd_pkg::BinW-1:0]      bin_diff;
  logic [DW:0]                   pair_sum;
  logic [DW-1:0]                 pair_dist;
  logic [DW-1:0]                 score;
  logic [hkd_pkg::TotalW:0]      total_sum;
  logic [hkd_pkg::TotalW-1:0]    total_sat;
  logic                          out_free;
  logic                          load_out;
  logic                          div_start;
  logic [DW-1:0]                 mean_sat;
  hkd_pkg::hkd_cell_ctl_t        cell_ctl;
  hkd_pkg::hkd_div_stat_t        div_stat;
  logic [hkd_pkg::TotalW-1:0]    div_quo;

  logic [hkd_pkg::WeightW-1:0]   weight_w [K_NEAREST];
  logic [DW-1:0]                 cell_val [K_NEAREST];
  logic                          cell_le  [K_NEAREST];
  logic                          left_le_w  [K_NEAREST];
  logic [DW-1:0]                 left_val_w [K_NEAREST];
  logic [DW-1:0]                 right_val_w[K_NEAREST];

  assign accept   = in_bus.valid && in_bus.ready;
  assign out_free = !out_valid_r || out_bus.ready;

  // Absolute bin difference and saturating pair sum
  assign bin_diff  = (in_bus.query_bin >= in_bus.target_bin) ?
                     (in_bus.query_bin - in_bus.target_bin) :
                     (in_bus.target_bin - in_bus.query_bin);
  assign pair_sum  = {1'b0, pair_r} + {{(DW + 1 - hkd_pkg::BinW){1'b0}}, bin_diff};
  assign pair_dist = pair_sum[DW] ? hkd_pkg::DistMax : pair_sum[DW-1:0];

  // Per-query score and saturating total
  assign score     = acc_r[AW-1] ? hkd_pkg::DistMax : acc_r[AW-2:hkd_pkg::WeightW];
  assign total_sum = {1'b0, total_r} + {{(hkd_pkg::TotalW + 1 - DW){1'b0}}, score};
  assign total_sat = total_sum[hkd_pkg::TotalW] ? hkd_pkg::TotalMax :
                     total_sum[hkd_pkg::TotalW-1:0];

  // Saturate the quotient to the mean range
  assign mean_sat = (count_r == '0) ? '0 :
                    (|div_quo[hkd_pkg::TotalW-1:DW]) ? hkd_pkg::DistMax : div_quo[DW-1:0];

  // Weight table and the row of list cells
  for (genvar i = 0; i < K_NEAREST; i++) begin : g_cell
    localparam int WRaw = ((K_NEAREST - i) * 65536) / (K_NEAREST * K_NEAREST);
    assign weight_w[i] = (WRaw > 65535) ? {hkd_pkg::WeightW{1'b1}} :
                         hkd_pkg::WeightW'(WRaw);

    if (i == 0) begin : g_head
      assign left_le_w[i]  = 1'b1;
      assign left_val_w[i] = hkd_pkg::DistMax;
    end else begin : g_body
      assign left_le_w[i]  = cell_le[i-1];
      assign left_val_w[i] = cell_val[i-1];
    end

    if (i == K_NEAREST - 1) begin : g_tail
      assign right_val_w[i] = hkd_pkg::DistMax;
    end else begin : g_mid
      assign right_val_w[i] = cell_val[i+1];
    end

    hkd_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (cell_ctl),
      .ins_dist  (pair_dist),
      .left_le   (left_le_w[i]),
      .left_val  (left_val_w[i]),
      .right_val (right_val_w[i]),
      .le        (cell_le[i]),
      .val       (cell_val[i])
    );
  end

  hkd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (total_r),
    .divisor  (count_r),
    .stat     (div_stat),
    .quotient (div_quo)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      hkd_pkg::StIdle: begin
        if (accept && in_bus.last_bin && in_bus.last_target) begin
          state_nxt = hkd_pkg::StScore;
        end
      end
      hkd_pkg::StScore: begin
        if (cnt_r == CntW'(K_NEAREST - 1)) begin
          state_nxt = hkd_pkg::StDrain;
        end
      end
      hkd_pkg::StDrain: begin
        state_nxt = hkd_pkg::StTotal;
      end
      hkd_pkg::StTotal: begin
        state_nxt = qlast_r ? hkd_pkg::StDivStart : hkd_pkg::StIdle;
      end
      hkd_pkg::StDivStart: begin
        state_nxt = hkd_pkg::StDivWait;
      end
      hkd_pkg::StDivWait: begin
        if (div_stat.done && out_free) begin
          state_nxt = hkd_pkg::StIdle;
        end
      end
      default: begin
        state_nxt = hkd_pkg::StIdle;
      end
    endcase
  end

  // Control outputs
  always_comb begin
    in_bus.ready    = 1'b0;
    cell_ctl.insert = 1'b0;
    cell_ctl.shift  = 1'b0;
    div_start       = 1'b0;
    load_out        = 1'b0;
    case (state_r)
      hkd_pkg::StIdle: begin
        in_bus.ready    = 1'b1;
        cell_ctl.insert = in_bus.valid && in_bus.last_bin;
      end
      hkd_pkg::StScore: begin
        cell_ctl.shift = 1'b1;
      end
      hkd_pkg::StDivStart: begin
        div_start = 1'b1;
      end
      hkd_pkg::StDivWait: begin
        load_out = div_stat.done && out_free;
      end
      default: begin
        in_bus.ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hkd_pkg::StIdle;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Hold the pair sum and the end-of-query flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pair_r  <= '0;
      qlast_r <= 1'b0;
    end else if (accept) begin
      pair_r  <= in_bus.last_bin ? '0 : pair_dist;
      qlast_r <= in_bus.last_query;
    end
  end

  // Weight the list head by head: multiply, then accumulate next cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      prod_v_r <= 1'b0;
      acc_r    <= '0;
    end else if (state_r == hkd_pkg::StIdle) begin
      cnt_r    <= '0;
      prod_v_r <= 1'b0;
      acc_r    <= '0;
    end else if (state_r == hkd_pkg::StScore) begin
      cnt_r    <= cnt_r + CntW'(1);
      prod_v_r <= 1'b1;
      if (prod_v_r) begin
        acc_r <= acc_r + AW'(prod_r);
      end
    end else if (state_r == hkd_pkg::StDrain) begin
      acc_r <= acc_r + AW'(prod_r);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == hkd_pkg::StScore) begin
      prod_r <= cell_val[0] * weight_w[cnt_r];
    end
  end

  // Add the query score unless the count limit is reached; clear after a result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
      count_r <= '0;
    end else if (load_out) begin
      total_r <= '0;
      count_r <= '0;
    end else if (state_r == hkd_pkg::StTotal && count_r < hkd_pkg::CountLimit) begin
      total_r <= total_sat;
      count_r <= count_r + hkd_pkg::CountW'(1);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_total_r <= total_r;
      out_count_r <= count_r;
      out_mean_r  <= mean_sat;
    end
  end

  assign out_bus.valid       = out_valid_r;
  assign out_bus.total_score = out_total_r;
  assign out_bus.query_count = out_count_r;
  assign out_bus.mean_score  = out_mean_r;

`ifndef SYNTH
  // End of a query holds off the next bin beat
  a_query_end_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_bus.last_bin && in_bus.last_target) |=> !in_bus.ready)
    else $error("bin beat taken during scoring pass");

  // Scoring pass leaves the list refilled with the sentinel
  a_list_refilled: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == hkd_pkg::StDrain) |->
      (cell_val[0] == hkd_pkg::DistMax && cell_val[K_NEAREST-1] == hkd_pkg::DistMax))
    else $error("list not refilled after scoring pass");

  // Dropped queries leave the total alone
  a_limit_holds_total: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == hkd_pkg::StTotal && count_r >= hkd_pkg::CountLimit) |=> $stable(total_r))
    else $error("total changed past the query limit");

  // Divider is free when a division starts
  a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == hkd_pkg::StDivStart) |-> !div_stat.busy)
    else $error("division started while divider busy");

  // A new result always counts at least one query
  a_result_count: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> (out_count_r != '0))
    else $error("result with zero query count");
`endif

endmodule

/* tb/tb.sv */
// Self-checking testbench for the K-nearest L1 histogram distance scorer.
module tb;

  localparam int KNear = 5;

  typedef struct {
    logic [hkd_pkg::TotalW-1:0] total_score;
    logic [hkd_pkg::CountW-1:0] query_count;
    logic [hkd_pkg::MeanW-1:0]  mean_score;
  } score_beat_t;

  // Predicts result beats from accepted bin beats and checks what comes out
  class knn_scoreboard;
    logic [hkd_pkg::DistW-1:0]  pair_sum;
    logic [hkd_pkg::DistW-1:0]  nearest [KNear];
    logic [hkd_pkg::TotalW-1:0] total;
    logic [hkd_pkg::CountW-1:0] count;
    score_beat_t                score_q [$];
    int                         errors;
    int                         results_made;

    function new();
      pair_sum = '0;
      total = '0;
      count = '0;
      errors = 0;
      results_made = 0;
      refill_nearest();
    endfunction

    function void refill_nearest();
      for (int i = 0; i < KNear; i++) nearest[i] = hkd_pkg::DistMax;
    endfunction

    // Insert after equal entries; the largest entry falls off the end
    function void insert_nearest(logic [hkd_pkg::DistW-1:0] d);
      int i;
      if (d >= nearest[KNear-1]) return;
      i = KNear - 1;
      while (i > 0 && nearest[i-1] > d) begin
        nearest[i] = nearest[i-1];
        i--;
      end
      nearest[i] = d;
    endfunction

    // Rank weight (K-i)/K^2 in Q0.16
    function longint unsigned rank_weight(int i);
      longint unsigned w;
      w = (longint'(KNear - i) << 16) / longint'(KNear * KNear);
      if (w > 65535) w = 65535;
      return w;
    endfunction

    function longint unsigned weighted_query_score();
      longint unsigned acc;
      acc = 0;
      for (int i = 0; i < KNear; i++) acc += rank_weight(i) * longint'(nearest[i]);
      acc = acc >> 16;
      if (acc > hkd_pkg::DistMax) acc = hkd_pkg::DistMax;
      return acc;
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
    endtask

    // Advance the predicted state by one accepted bin beat
    function void note_beat(logic [hkd_pkg::BinW-1:0] q, logic [hkd_pkg::BinW-1:0] t,
                            logic lb, logic lt, logic lq);
      int unsigned     diff;
      int unsigned     sum;
      longint unsigned tot;
      longint unsigned mean;
      score_beat_t     beat;
      diff = (q >= t) ? q - t : t - q;
      sum = int'(pair_sum) + diff;
      pair_sum = (sum > hkd_pkg::DistMax) ? hkd_pkg::DistMax : hkd_pkg::DistW'(sum);
      if (!lb) return;
      insert_nearest(pair_sum);
      pair_sum = '0;
      if (!lt) return;
      // Drop queries past the count limit
      if (count < hkd_pkg::CountLimit) begin
        tot = longint'(total) + weighted_query_score();
        total = (tot > hkd_pkg::TotalMax) ? hkd_pkg::TotalMax : hkd_pkg::TotalW'(tot);
        count++;
      end
      refill_nearest();
      if (!lq) return;
      mean = (count != 0) ? longint'(total) / longint'(count) : 0;
      if (mean > hkd_pkg::DistMax) mean = hkd_pkg::DistMax;
      beat.total_score = total;
      beat.query_count = count;
      beat.mean_score = hkd_pkg::MeanW'(mean);
      score_q = {score_q, beat};
      results_made++;
      total = '0;
      count = '0;
    endfunction

    task check_result(logic [hkd_pkg::TotalW-1:0] ts, logic [hkd_pkg::CountW-1:0] qc,
                      logic [hkd_pkg::MeanW-1:0] ms);
      score_beat_t want;
      if (score_q.size() == 0) begin
        report($sformatf("unexpected result total=%0d count=%0d mean=%0d", ts, qc, ms));
        return;
      end
      want = score_q.pop_front();
      if (ts !== want.total_score)
        report($sformatf("total_score %0d, want %0d", ts, want.total_score));
      if (qc !== want.query_count)
        report($sformatf("query_count %0d, want %0d", qc, want.query_count));
      if (ms !== want.mean_score)
        report($sformatf("mean_score %0d, want %0d", ms, want.mean_score));
    endtask

    function int pending();
      return score_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   send_idle;
  int   recv_idle;
  int   beats_sent;

  knn_scoreboard score;

  hkd_in_if  in_ch ();
  hkd_out_if out_ch ();

  histogram_knn_distance_score #(.K_NEAREST(KNear)) DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_ch),
    .out_bus (out_ch)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Stall the result side at random
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle);
  end

  // Check every accepted result beat
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      score.check_result(out_ch.total_score, out_ch.query_count, out_ch.mean_score);
  end

  initial begin
    #5000000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic logic [hkd_pkg::BinW-1:0] pick_bin(int mode);
    case (mode)
      0: return hkd_pkg::BinW'($urandom_range(65535));
      1: return hkd_pkg::BinW'($urandom_range(3));
      default: return $urandom_range(1) ? {hkd_pkg::BinW{1'b1}} : '0;
    endcase
  endfunction

  // Drive one bin beat, idling first at random, and hold it until taken
  task automatic send_beat(logic [hkd_pkg::BinW-1:0] q, logic [hkd_pkg::BinW-1:0] t,
                           logic lb, logic lt, logic lq);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.query_bin   <= q;
    in_ch.target_bin  <= t;
    in_ch.last_bin    <= lb;
    in_ch.last_target <= lt;
    in_ch.last_query  <= lq;
    do @(posedge clk); while (!in_ch.ready);
    score.note_beat(q, t, lb, lt, lq);
    beats_sent++;
  endtask

  // One descriptor pair; inner beats carry stray flags now and then
  task automatic send_pair(int nbins, int mode, logic lt, logic lq);
    for (int k = 0; k < nbins; k++) begin
      if (k == nbins - 1)
        send_beat(pick_bin(mode), pick_bin(mode), 1'b1, lt, lq);
      else
        send_beat(pick_bin(mode), pick_bin(mode), 1'b0,
                  $urandom_range(4) == 0, $urandom_range(4) == 0);
    end
  endtask

  task automatic send_query(int ntargets, int maxbins, logic final_q);
    logic last;
    for (int j = 0; j < ntargets; j++) begin
      last = (j == ntargets - 1);
      send_pair($urandom_range(1, maxbins), $urandom_range(2), last,
                last ? final_q : 1'($urandom_range(1)));
    end
  endtask

  // One well-formed run of queries, sometimes led by loose beats
  task automatic send_run();
    int nq;
    nq = $urandom_range(1, 3);
    if ($urandom_range(6) == 0) begin
      repeat ($urandom_range(1, 4))
        send_beat(pick_bin(0), pick_bin(0), 1'($urandom_range(1)),
                  1'($urandom_range(1)), 1'($urandom_range(1)));
    end
    for (int qi = 0; qi < nq; qi++)
      send_query($urandom_range(1, 7), ($urandom_range(9) == 0) ? 16 : 4, qi == nq - 1);
  endtask

  initial begin
    score = new();
    send_idle = 0;
    recv_idle = 0;
    beats_sent = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.query_bin = '0;
    in_ch.target_bin = '0;
    in_ch.last_bin = 1'b0;
    in_ch.last_target = 1'b0;
    in_ch.last_query = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Largest difference both ways, single-target queries with sentinel entries
    send_beat({hkd_pkg::BinW{1'b1}}, '0, 1'b1, 1'b1, 1'b1);
    send_beat('0, {hkd_pkg::BinW{1'b1}}, 1'b1, 1'b1, 1'b1);
    send_beat('0, '0, 1'b1, 1'b1, 1'b1);
    // More than K targets with ties, so entries shift and drop out
    send_beat(hkd_pkg::BinW'(5), '0, 1'b1, 1'b0, 1'b0);
    send_beat(hkd_pkg::BinW'(3), '0, 1'b1, 1'b0, 1'b1);
    send_beat(hkd_pkg::BinW'(5), '0, 1'b1, 1'b0, 1'b0);
    send_beat(hkd_pkg::BinW'(3), '0, 1'b1, 1'b0, 1'b0);
    send_beat(hkd_pkg::BinW'(9), '0, 1'b1, 1'b0, 1'b0);
    send_beat(hkd_pkg::BinW'(1), '0, 1'b1, 1'b1, 1'b0);
    send_beat('0, hkd_pkg::BinW'(3), 1'b1, 1'b0, 1'b0);
    send_beat('0, hkd_pkg::BinW'(3), 1'b1, 1'b1, 1'b1);
    // Stray flags without last_bin or last_target
    send_beat(hkd_pkg::BinW'(100), hkd_pkg::BinW'(7), 1'b0, 1'b1, 1'b1);
    send_beat(hkd_pkg::BinW'(20), hkd_pkg::BinW'(900), 1'b0, 1'b0, 1'b1);
    send_beat(hkd_pkg::BinW'(1), hkd_pkg::BinW'(2), 1'b1, 1'b0, 1'b1);
    send_beat({hkd_pkg::BinW{1'b1}}, {hkd_pkg::BinW{1'b1}}, 1'b1, 1'b1, 1'b1);
    // Multi-bin pairs at the extremes
    send_beat({hkd_pkg::BinW{1'b1}}, '0, 1'b0, 1'b0, 1'b0);
    send_beat({hkd_pkg::BinW{1'b1}}, '0, 1'b1, 1'b0, 1'b0);
    send_beat('0, {hkd_pkg::BinW{1'b1}}, 1'b0, 1'b0, 1'b0);
    send_beat(hkd_pkg::BinW'(16'h5555), hkd_pkg::BinW'(16'hAAAA), 1'b1, 1'b1, 1'b1);

    // Random runs over three idling phases
    while (beats_sent < 415) begin
      if (beats_sent < 150) begin
        send_idle = 20;
        recv_idle = 54;
      end else if (beats_sent < 285) begin
        send_idle = 54;
        recv_idle = 20;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      send_run();
    end

    // Saturate one pair distance, then end the run with a short target
    for (int k = 0; k < 130; k++)
      send_beat({hkd_pkg::BinW{1'b1}}, '0, k == 129, 1'b0, 1'b0);
    send_pair(3, 0, 1'b1, 1'b1);
    in_ch.valid <= 1'b0;

    // Drain outstanding results, then watch for strays
    while (score.pending() != 0) @(posedge clk);
    repeat (KNear + 60) @(posedge clk);
    if (score.errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end
endmodule
